FILE: hdl/gbn_pkg.sv
package gbn_pkg;

    localparam int SEQ_BITS      = 3;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int STORE_DEPTH   = 2 ** SEQ_BITS;

    typedef logic [SEQ_BITS-1:0]      seq_t;
    typedef logic [PAYLOAD_WIDTH-1:0] payload_t;

    typedef enum logic [1:0] {
        OP_PACKET  = 2'd0,
        OP_FRAME   = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_RESTART = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        KIND_SENT    = 2'd0,
        KIND_ARRIVAL = 2'd1,
        KIND_REFUSED = 2'd2
    } kind_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_RD,
        ST_SEND
    } state_e;

    typedef struct packed {
        logic [1:0] operation;
        payload_t   packet_word;
        seq_t       frame_seq;
        seq_t       frame_ack;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        seq_t       seq_out;
        seq_t       ack_out;
        payload_t   payload_out;
        logic       retransmit;
        logic       delivered;
        seq_t       freed_count;
        logic       window_open;
        logic       last;
    } out_item_t;

    // one-hot (or all-zero) commands from controller to datapath
    typedef struct packed {
        logic cfg_write;
        logic clear;
        logic send_new;
        logic refuse;
        logic arrive;
        logic free_step;
        logic report;
        logic rtx_start;
        logic rtx_read;
        logic rtx_send;
    } dp_cmd_t;

    typedef struct packed {
        logic window_full;
        logic none_outstanding;
        logic ack_between;
        logic rtx_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/gbn_ctrl.sv
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    output logic       op_ready,
    input  logic [1:0] operation,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        op_ready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                // a config beat takes precedence over an item
                op_ready  = status.out_free && !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                end
                else if (op_valid && status.out_free)
                begin
                    case (op_e'(operation))
                        OP_PACKET:
                        begin
                            if (status.window_full)
                            begin
                                cmd.refuse = 1'b1;
                            end
                            else
                            begin
                                cmd.send_new = 1'b1;
                            end
                        end
                        OP_FRAME:
                        begin
                            cmd.arrive = 1'b1;
                            state_next = ST_FREE;
                        end
                        OP_TIMEOUT:
                        begin
                            if (!status.none_outstanding)
                            begin
                                cmd.rtx_start = 1'b1;
                                state_next    = ST_RD;
                            end
                        end
                        OP_RESTART:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            cmd.clear = 1'b1;
                        end
                    endcase
                end
            end
            ST_FREE:
            begin
                // release one acknowledged slot per cycle, then report
                if (status.ack_between)
                begin
                    cmd.free_step = 1'b1;
                end
                else
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rtx_read = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.rtx_send = 1'b1;
                    state_next   = status.rtx_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("gbn_ctrl: more than one datapath command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && !status.out_free) |=> state_reg == ST_SEND)
        else $error("gbn_ctrl: left resend while result slot busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_ready || op_ready) |-> state_reg == ST_IDLE)
        else $error("gbn_ctrl: beat taken while busy");

endmodule

FILE: hdl/gbn_dp.sv
module gbn_dp
    import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  in_item_t   op_item,
    input  logic [1:0] cfg_data,
    output logic       res_valid,
    input  logic       res_ready,
    output out_item_t  res_item
);

    logic [1:0] seq_bits_reg;
    seq_t       next_reg;
    seq_t       oldest_reg;
    seq_t       expected_reg;
    seq_t       outstanding_reg;
    seq_t       rtx_cnt_reg;
    logic       res_valid_reg;

    seq_t       fack_reg;
    payload_t   word_reg;
    logic       dlv_reg;
    seq_t       freed_reg;
    payload_t   rd_data_reg;
    out_item_t  res_item_reg;
    out_item_t  res_item_next;

    payload_t   store_mem [STORE_DEPTH];

    logic [1:0] m_eff;
    seq_t       seq_mask;
    seq_t       ack_now;
    seq_t       out_after_send;
    logic       res_load;

    function automatic seq_t seq_succ(seq_t v, seq_t mask);
        return seq_t'(v + 1'b1) & mask;
    endfunction

    function automatic logic circ_between(seq_t a, seq_t b, seq_t c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    always_comb
    begin
        m_eff = (seq_bits_reg == 2'd0) ? 2'd1 : seq_bits_reg;
        if (m_eff > SEQ_BITS)
        begin
            m_eff = 2'(SEQ_BITS);
        end
    end

    assign seq_mask       = seq_t'((1 << m_eff) - 1);
    assign ack_now        = seq_t'(expected_reg - 1'b1) & seq_mask;
    assign out_after_send = seq_t'(outstanding_reg + 1'b1);
    assign res_load       = cmd.send_new | cmd.refuse | cmd.report | cmd.rtx_send;

    assign status.window_full      = !(outstanding_reg < seq_mask);
    assign status.none_outstanding = (outstanding_reg == '0);
    assign status.ack_between      = (fack_reg <= seq_mask)
                                     && circ_between(oldest_reg, fack_reg, next_reg);
    assign status.rtx_last         = (rtx_cnt_reg == seq_t'(1));
    assign status.out_free         = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_bits_reg    <= 2'd3;
            next_reg        <= '0;
            oldest_reg      <= '0;
            expected_reg    <= '0;
            outstanding_reg <= '0;
            rtx_cnt_reg     <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cmd.cfg_write || cmd.clear)
            begin
                next_reg        <= '0;
                oldest_reg      <= '0;
                expected_reg    <= '0;
                outstanding_reg <= '0;
            end
            if (cmd.cfg_write)
            begin
                seq_bits_reg <= cfg_data;
            end
            if (cmd.send_new)
            begin
                outstanding_reg <= out_after_send;
                next_reg        <= seq_succ(next_reg, seq_mask);
            end
            if (cmd.arrive && op_item.frame_seq == expected_reg)
            begin
                expected_reg <= seq_succ(expected_reg, seq_mask);
            end
            if (cmd.free_step)
            begin
                oldest_reg <= seq_succ(oldest_reg, seq_mask);
                if (outstanding_reg != '0)
                begin
                    outstanding_reg <= seq_t'(outstanding_reg - 1'b1);
                end
            end
            if (cmd.rtx_start)
            begin
                // rewind to the oldest unacknowledged frame
                next_reg    <= oldest_reg;
                rtx_cnt_reg <= outstanding_reg;
            end
            if (cmd.rtx_send)
            begin
                next_reg    <= seq_succ(next_reg, seq_mask);
                rtx_cnt_reg <= seq_t'(rtx_cnt_reg - 1'b1);
            end
        end
    end

    // frame store and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.send_new)
        begin
            store_mem[next_reg] <= op_item.packet_word;
        end
        if (cmd.rtx_read)
        begin
            rd_data_reg <= store_mem[next_reg];
        end
        if (cmd.arrive)
        begin
            fack_reg  <= op_item.frame_ack;
            word_reg  <= op_item.packet_word;
            dlv_reg   <= (op_item.frame_seq == expected_reg);
            freed_reg <= '0;
        end
        if (cmd.free_step)
        begin
            freed_reg <= seq_t'(freed_reg + 1'b1);
        end
        if (res_load)
        begin
            res_item_reg <= res_item_next;
        end
    end

    always_comb
    begin
        res_item_next = '0;
        res_item_next.last = 1'b1;
        if (cmd.send_new)
        begin
            res_item_next.kind        = KIND_SENT;
            res_item_next.seq_out     = next_reg;
            res_item_next.ack_out     = ack_now;
            res_item_next.payload_out = op_item.packet_word;
            res_item_next.window_open = out_after_send < seq_mask;
        end
        else if (cmd.refuse)
        begin
            res_item_next.kind = KIND_REFUSED;
        end
        else if (cmd.report)
        begin
            res_item_next.kind        = KIND_ARRIVAL;
            res_item_next.payload_out = dlv_reg ? word_reg : '0;
            res_item_next.delivered   = dlv_reg;
            res_item_next.freed_count = freed_reg;
            res_item_next.window_open = outstanding_reg < seq_mask;
        end
        else
        begin
            res_item_next.kind        = KIND_SENT;
            res_item_next.seq_out     = next_reg;
            res_item_next.ack_out     = ack_now;
            res_item_next.payload_out = rd_data_reg;
            res_item_next.retransmit  = 1'b1;
            res_item_next.window_open = outstanding_reg < seq_mask;
            res_item_next.last        = (rtx_cnt_reg == seq_t'(1));
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || res_ready))
        else $error("gbn_dp: result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rtx_send |-> rtx_cnt_reg != '0)
        else $error("gbn_dp: resend with empty count");

    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= seq_mask)
        else $error("gbn_dp: outstanding count beyond window");

endmodule

FILE: hdl/go_back_n_arq.sv
// Packet: result valid in the cycle after the taken beat; one per cycle unless stalled.
// Arrival: the ack frees k slots (0..7), one per cycle, then the result is loaded.
// Timeout: per resent frame, a store read, then a result load once the result slot is free.
// Restart and config writes give no result.
// Reset (rst_n low, async): pointers and counts cleared, seq_bits = 3; the frame
// store is not cleared and holds nothing meaningful until written.
module go_back_n_arq
    import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    output logic       op_ready,
    input  in_item_t   op_item,
    output logic       res_valid,
    input  logic       res_ready,
    output out_item_t  res_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .operation (op_item.operation),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gbn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op_item   (op_item),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

FILE: bench/gbn_checker.sv
`timescale 1ns / 100ps

module gbn_checker
    import gbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    input  logic       op_ready,
    input  in_item_t   op_item,
    input  logic       res_valid,
    input  logic       res_ready,
    input  out_item_t  res_item,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         result_count
);

    logic [1:0]  width_reg;
    seq_t        tx_next;
    seq_t        tx_oldest;
    seq_t        rx_expected;
    int unsigned in_flight;
    payload_t    tx_copy [STORE_DEPTH];
    out_item_t   due_results [$];
    out_item_t   want;
    int          failures = 0;
    int          checked  = 0;

    function automatic int unsigned seq_modulus(input logic [1:0] w);
        int unsigned m;
        m = 32'(w);
        if (m == 0) m = 1;
        if (m > SEQ_BITS) m = SEQ_BITS;
        return 1 << m;
    endfunction

    function automatic seq_t wrap_inc(input seq_t v, input int unsigned mod);
        return seq_t'((v + 1) & (mod - 1));
    endfunction

    // circular a <= b < c
    function automatic bit lies_between(input seq_t a, b, c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    task automatic clear_links();
        tx_next     = '0;
        tx_oldest   = '0;
        rx_expected = '0;
        in_flight   = 0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            failures++;
        end
    endtask

    task automatic advance_link(input in_item_t it);
        int unsigned mod;
        int unsigned max_seq;
        int unsigned n;
        seq_t        ack_now;
        seq_t        s;
        logic [2:0]  freed;
        out_item_t   r;
        mod     = seq_modulus(width_reg);
        max_seq = mod - 1;
        ack_now = seq_t'((rx_expected + max_seq) & (mod - 1));
        r       = '0;
        r.last  = 1'b1;
        case (it.operation)
            OP_PACKET:
            begin
                if (in_flight < max_seq)
                begin
                    s = tx_next;
                    tx_copy[s] = it.packet_word;
                    in_flight++;
                    tx_next = wrap_inc(tx_next, mod);
                    r.kind        = KIND_SENT;
                    r.seq_out     = s;
                    r.ack_out     = ack_now;
                    r.payload_out = it.packet_word;
                    r.window_open = in_flight < max_seq;
                end
                else
                begin
                    r.kind = KIND_REFUSED;
                end
                due_results = {due_results, r};
            end
            OP_FRAME:
            begin
                freed = '0;
                r.kind = KIND_ARRIVAL;
                if (it.frame_seq == rx_expected)
                begin
                    r.delivered   = 1'b1;
                    r.payload_out = it.packet_word;
                    rx_expected   = wrap_inc(rx_expected, mod);
                end
                // cumulative ack: release everything up to and including frame_ack
                if (it.frame_ack < mod)
                begin
                    while (lies_between(tx_oldest, it.frame_ack, tx_next))
                    begin
                        if (in_flight > 0) in_flight--;
                        tx_oldest = wrap_inc(tx_oldest, mod);
                        freed++;
                    end
                end
                r.freed_count = freed;
                r.window_open = in_flight < max_seq;
                due_results = {due_results, r};
            end
            OP_TIMEOUT:
            begin
                n = in_flight;
                tx_next = tx_oldest;
                for (int i = 0; i < n; i++)
                begin
                    r = '0;
                    r.kind        = KIND_SENT;
                    r.seq_out     = tx_next;
                    r.ack_out     = ack_now;
                    r.payload_out = tx_copy[tx_next];
                    r.retransmit  = 1'b1;
                    r.window_open = n < max_seq;
                    r.last        = (i + 1 == n);
                    due_results = {due_results, r};
                    tx_next = wrap_inc(tx_next, mod);
                end
            end
            default: clear_links();
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = 2'd3;
            clear_links();
            due_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                width_reg = cfg_data;
                clear_links();
            end
            if (res_valid && res_ready)
            begin
                checked++;
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d seq %0d",
                           res_item.kind, res_item.seq_out);
                    failures++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_item.kind));
                    check_field("seq_out", 32'(want.seq_out), 32'(res_item.seq_out));
                    check_field("ack_out", 32'(want.ack_out), 32'(res_item.ack_out));
                    check_field("payload_out", want.payload_out, res_item.payload_out);
                    check_field("retransmit", 32'(want.retransmit),
                                32'(res_item.retransmit));
                    check_field("delivered", 32'(want.delivered), 32'(res_item.delivered));
                    check_field("freed_count", 32'(want.freed_count),
                                32'(res_item.freed_count));
                    check_field("window_open", 32'(want.window_open),
                                32'(res_item.window_open));
                    check_field("last", 32'(want.last), 32'(res_item.last));
                end
            end
            if (op_valid && op_ready)
                advance_link(op_item);
        end
        pending      <= due_results.size();
        fail_count   <= failures;
        result_count <= checked;
    end

endmodule

FILE: bench/tb_go_back_n_arq.sv
`timescale 1ns / 100ps

module tb_go_back_n_arq;
    import gbn_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 24;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       op_valid  = 1'b0;
    logic       op_ready;
    in_item_t   op_item   = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    out_item_t  res_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = 2'd0;

    int          fail_count;
    int          pending;
    int          result_count;
    int          cycles     = 0;
    int          items_sent = 0;
    int          stall_left = 0;
    bit          res_calm   = 1'b0;
    bit          op_calm    = 1'b0;
    int unsigned cur_mod    = 8;
    int unsigned peer_seq   = 0;

    go_back_n_arq dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_item   (op_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gbn_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op_item      (op_item),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_item     (res_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("cycle limit reached with %0d results outstanding", pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver back-pressure: mostly short stalls, a few long, calm stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 99) == 0) res_calm = !res_calm;
            if (!res_calm && $urandom_range(0, 99) < 25) stall_left = idle_len(1'b0);
        end
    end

    function automatic in_item_t make_item(input op_e op, input payload_t word,
                                           input seq_t fseq, input seq_t fack);
        in_item_t it;
        it.operation   = op;
        it.packet_word = word;
        it.frame_seq   = fseq;
        it.frame_ack   = fack;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        it.packet_word = $urandom();
        if (r < 15)
        begin
            // noise: any code, any frame numbers
            it.operation = 2'($urandom_range(0, 3));
            it.frame_seq = seq_t'($urandom_range(0, 7));
            it.frame_ack = seq_t'($urandom_range(0, 7));
            return it;
        end
        r = $urandom_range(0, 99);
        it.frame_ack = seq_t'($urandom_range(0, cur_mod - 1));
        it.frame_seq = ($urandom_range(0, 99) < 85) ? seq_t'(peer_seq)
                                                    : seq_t'($urandom_range(0, cur_mod - 1));
        if (r < 46)      it.operation = OP_PACKET;
        else if (r < 80) it.operation = OP_FRAME;
        else if (r < 98) it.operation = OP_TIMEOUT;
        else             it.operation = OP_RESTART;
        return it;
    endfunction

    task automatic push_op(input in_item_t it);
        int gap;
        @(negedge clk);
        op_valid <= 1'b1;
        op_item  <= it;
        do @(posedge clk); while (!op_ready);
        items_sent++;
        // track the peer's in-order sequence so most frames land in order
        if (it.operation == OP_FRAME && it.frame_seq == peer_seq)
            peer_seq = (peer_seq + 1) % cur_mod;
        else if (it.operation == OP_RESTART)
            peer_seq = 0;
        gap = idle_len(op_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            op_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic set_width(input logic [1:0] w);
        @(negedge clk);
        op_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        // let a restart or an empty timeout drain
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        peer_seq = 0;
        cur_mod  = 1 << ((w == 0) ? 1 : ((w > SEQ_BITS) ? SEQ_BITS : w));
    endtask

    initial
    begin
        logic [1:0] width;
        int         n_items;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_op(make_item(OP_TIMEOUT, '0, '0, '0));
        push_op(make_item(OP_PACKET, 32'h0000_0000, '0, '0));
        push_op(make_item(OP_PACKET, 32'hFFFF_FFFF, 3'd7, 3'd7));
        repeat (5) push_op(make_item(OP_PACKET, $urandom(), '0, '0));
        // window full: refuse, then resend all seven
        push_op(make_item(OP_PACKET, $urandom(), '0, '0));
        push_op(make_item(OP_TIMEOUT, '0, '0, '0));
        push_op(make_item(OP_FRAME, 32'hFFFF_FFFF, 3'd0, 3'd7));
        push_op(make_item(OP_FRAME, $urandom(), 3'd5, 3'd6));
        push_op(make_item(OP_FRAME, 32'h0000_0000, 3'd1, 3'd0));
        push_op(make_item(OP_RESTART, $urandom(), '0, '0));
        push_op(make_item(OP_FRAME, $urandom(), 3'd7, 3'd7));
        push_op(make_item(OP_PACKET, $urandom(), '0, '0));
        push_op(make_item(OP_TIMEOUT, '0, '0, '0));
        push_op(make_item(OP_RESTART, '0, '0, '0));

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       begin width = 2'd3; n_items = 90; end
                1:       begin width = 2'd1; n_items = 66; end
                2:       begin width = 2'd0; n_items = 50; end
                3:       begin width = 2'd2; n_items = 70; end
                default: begin width = 2'd3; n_items = 70; end
            endcase
            if (phase != 0) set_width(width);
            if (phase == 1)
            begin
                // frame numbers beyond the narrow modulus
                push_op(make_item(OP_PACKET, $urandom(), '0, '0));
                push_op(make_item(OP_FRAME, $urandom(), 3'd2, 3'd3));
                push_op(make_item(OP_FRAME, $urandom(), 3'd0, 3'd0));
                push_op(make_item(OP_FRAME, $urandom(), 3'd6, 3'd5));
            end
            for (int i = 0; i < n_items; i++)
            begin
                if (i % 25 == 0) op_calm = ($urandom_range(0, 4) == 0);
                push_op(random_item());
            end
        end

        @(negedge clk);
        op_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d op beats and checked %0d result beats at seq_bits 3, 1, 0, 2, 3",
                 items_sent, result_count);
        $display("Included full-window refusal, seven-frame resend and release, stale frames");
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hdl/gbn_pkg.sv
hdl/gbn_ctrl.sv
hdl/gbn_dp.sv
hdl/go_back_n_arq.sv
bench/gbn_checker.sv
bench/tb_go_back_n_arq.sv
